@@ rtl/fswls_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fswls_pkg: shared types and constants for the sticky weighted link selector
// Holds table geometry, register indexes, protocol codes, flow phases and the
// sequencer state type.
// ----------------------------------------------------------------------------
package fswls_pkg;

	localparam int Links   = 4;
	localparam int Flows   = 64;
	localparam int FlowW   = (Flows > 1) ? $clog2(Flows) : 1;
	localparam int FlowCntW = $clog2(Flows + 1);

	localparam logic [2:0] RegLink0 = 3'd0;
	localparam logic [2:0] RegLink1 = 3'd1;
	localparam logic [2:0] RegLink2 = 3'd2;
	localparam logic [2:0] RegLink3 = 3'd3;
	localparam logic [2:0] RegStale = 3'd4;

	localparam logic [7:0] ProtoTcp = 8'd6;
	localparam logic [7:0] ProtoUdp = 8'd17;
	localparam logic [3:0] Ver4     = 4'd4;
	localparam logic [3:0] Ver6     = 4'd6;

	localparam logic [1:0] PhClosed     = 2'd0;
	localparam logic [1:0] PhConnected  = 2'd1;
	localparam logic [1:0] PhConnecting = 2'd2;
	localparam logic [1:0] PhClosing    = 2'd3;

	// one flow table row
	typedef struct packed {
		logic [63:0] src_hi;
		logic [63:0] src_lo;
		logic [63:0] dst_hi;
		logic [63:0] dst_lo;
		logic [31:0] ports;
		logic [7:0]  proto;
		logic [2:0]  link;
		logic [1:0]  phase;
		logic [31:0] stamp;
	} row_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WAIT,
		ST_DECIDE,
		ST_PICK,
		ST_APPLY,
		ST_OUT
	} state_t;

	// pick unit control and status
	typedef struct packed {
		logic       start;
		logic [30:0] draw;
		logic [3:0] mask;
	} pick_req_t;

	typedef struct packed {
		logic       busy;
		logic       done;
		logic       ok;
		logic [1:0] link;
	} pick_rsp_t;

endpackage

@@ rtl/fswls_pick.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fswls_pick: weighted random link pick
// Restoring modulo, one quotient bit a cycle, then a walk over
// the links with one shared add and compare, one link a cycle.
// ----------------------------------------------------------------------------
module fswls_pick (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [7:0]             weight [fswls_pkg::Links],
	input  fswls_pkg::pick_req_t   req,
	output fswls_pkg::pick_rsp_t   rsp
);
	import fswls_pkg::*;

	typedef enum logic [1:0] {P_IDLE, P_MOD, P_WALK} pstate_t;

	localparam int LinkW = $clog2(Links + 1);

	pstate_t     state_q;
	logic [9:0]  total_q;
	logic [9:0]  rem_q;
	logic [30:0] draw_q;
	logic [4:0]  bit_q;
	logic [3:0]  mask_q;
	logic [LinkW-1:0] idx_q;
	logic [9:0]  acc_q;
	logic        done_q;
	logic        ok_q;
	logic [1:0]  link_q;

	logic [9:0]  total_c;
	logic [10:0] shifted;
	logic [10:0] acc_next;
	logic        counts;

	always_comb begin
		total_c = '0;
		for (int i = 0; i < Links; i++) begin
			if (req.mask[i])
				total_c = total_c + {2'd0, weight[i]};
		end
	end

	assign shifted  = {rem_q, draw_q[30]};
	assign counts   = mask_q[idx_q[1:0]];
	assign acc_next = {1'b0, acc_q} + {3'd0, weight[idx_q[1:0]]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= P_IDLE;
			done_q  <= 1'b0;
			ok_q    <= 1'b0;
			link_q  <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				P_IDLE: begin
					if (req.start) begin
						total_q <= total_c;
						draw_q  <= req.draw;
						mask_q  <= req.mask;
						rem_q   <= '0;
						bit_q   <= '0;
						if (total_c == '0) begin
							done_q <= 1'b1;
							ok_q   <= 1'b0;
						end else begin
							state_q <= P_MOD;
						end
					end
				end
				P_MOD: begin
					if (shifted >= {1'b0, total_q})
						rem_q <= 10'(shifted - {1'b0, total_q});
					else
						rem_q <= shifted[9:0];
					draw_q <= {draw_q[29:0], 1'b0};
					bit_q  <= 5'(bit_q + 5'd1);
					if (bit_q == 5'd30) begin
						state_q <= P_WALK;
						idx_q   <= '0;
						acc_q   <= '0;
					end
				end
				P_WALK: begin
					if (counts) begin
						acc_q <= acc_next[9:0];
						if (acc_next > {1'b0, rem_q}) begin
							state_q <= P_IDLE;
							done_q  <= 1'b1;
							ok_q    <= 1'b1;
							link_q  <= idx_q[1:0];
						end
					end
					idx_q <= LinkW'(idx_q + 1'b1);
					if (int'(idx_q) == Links - 1 && !(counts && acc_next > {1'b0, rem_q})) begin
						state_q <= P_IDLE;
						done_q  <= 1'b1;
						ok_q    <= 1'b0;
					end
				end
				default: state_q <= P_IDLE;
			endcase
		end
	end

	assign rsp.busy = (state_q != P_IDLE);
	assign rsp.done = done_q;
	assign rsp.ok   = ok_q;
	assign rsp.link = link_q;

`ifndef SYNTHESIS
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("pick done held");
	a_link_active: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && ok_q) |-> mask_q[link_q]) else $error("pick chose inactive link");
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == P_WALK) |-> (rem_q < total_q)) else $error("remainder out of range");
`endif

endmodule

@@ rtl/fswls_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fswls_table: flow table storage
// Row memory with one write and one registered read port, plus valid bits.
// ----------------------------------------------------------------------------
module fswls_table (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [fswls_pkg::FlowW-1:0] rd_addr,
	output fswls_pkg::row_t             rd_row,
	output logic                        rd_valid,
	input  logic                        wr_en,
	input  logic [fswls_pkg::FlowW-1:0] wr_addr,
	input  fswls_pkg::row_t             wr_row,
	input  logic                        vld_set,
	input  logic                        vld_clr,
	input  logic [fswls_pkg::FlowW-1:0] vld_addr
);
	import fswls_pkg::*;

	row_t              mem [Flows];
	logic [Flows-1:0]  valid_q;
	row_t              rd_row_q;
	logic              rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_row;
		rd_row_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			rd_valid_q <= valid_q[rd_addr];
			if (vld_set)
				valid_q[vld_addr] <= 1'b1;
			else if (vld_clr)
				valid_q[vld_addr] <= 1'b0;
		end
	end

	assign rd_row   = rd_row_q;
	assign rd_valid = rd_valid_q;

endmodule

@@ rtl/flow_sticky_weighted_link_select.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flow_sticky_weighted_link_select: per-flow sticky weighted link balancer
// Exact-match flow table with sequential search and a shared pick unit.
// A TCP/UDP word scans the whole table, one row per cycle, then a pick runs if
//   needed (restoring modulo, then a walk of up to 4 links); other protocols
//   skip the scan, and a bad version skips the scan and the pick.
// Throughput: one word at a time; no new word is taken until the last result
//   is loaded into the output register; the table scan and the modulo set it.
// Reset: weights 1, stale limit 5, all table rows invalid; no clearing pass.
// ----------------------------------------------------------------------------
module flow_sticky_weighted_link_select (
	input  logic         clk,
	input  logic         arst_n,
	// s: ip_version[3:0], src_addr_hi[67:4], src_addr_lo[131:68],
	//    dst_addr_hi[195:132], dst_addr_lo[259:196], src_port[275:260],
	//    dst_port[291:276], protocol[299:292], tcp_flags[302:300],
	//    now_seconds[334:303], random_draw[365:335], link_active_mask[369:366]
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [375:0] s_tdata,
	// m: link_valid[0], link_index[2:1], flow_not_stored[3]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [7:0]   m_tdata,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [7:0]   cfg_data
);
	import fswls_pkg::*;

	// configuration
	logic [7:0] weight_q [Links];
	logic [7:0] stale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < Links; i++)
				weight_q[i] <= 8'd1;
			stale_q <= 8'd5;
		end else if (cfg_we) begin
			case (cfg_index)
				RegLink0: weight_q[0] <= cfg_data;
				RegLink1: weight_q[1] <= cfg_data;
				RegLink2: weight_q[2] <= cfg_data;
				RegLink3: weight_q[3] <= cfg_data;
				RegStale: stale_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// captured packet, IPv4 addresses already mapped
	logic [3:0]  ver_q;
	row_t        key_q;      // link/phase/stamp unused in key compare
	logic [2:0]  flags_q;
	logic [30:0] draw_q;
	logic [3:0]  mask_q;

	state_t state_q, state_d;

	// scan bookkeeping
	logic [FlowCntW-1:0] scan_q;    // address issued
	logic [FlowCntW-1:0] chk_q;     // address of the returning row
	logic                chk_v_q;
	logic                hit_q, free_q;
	logic [FlowW-1:0]    hit_idx_q, free_idx_q;
	row_t                hit_row_q;

	// decision
	logic       need_pick_q;
	logic       pick_ok_q;
	logic [1:0] pick_link_q;
	logic       out_valid_q;
	logic [1:0] out_link_q;
	logic       out_ns_q;
	logic [7:0] m_tdata_q;
	logic       pick_needed;
	logic       out_ns_q_d;

	pick_req_t  preq;
	pick_rsp_t  prsp;

	row_t             rd_row;
	logic             rd_valid;
	logic             wr_en, vld_set, vld_clr;
	logic [FlowW-1:0] wr_addr, vld_addr;
	row_t             wr_row;

	logic is_v4, ver_ok, is_tcp, is_udp;
	logic key_match;
	logic [31:0] age;
	logic hit_link_live;
	logic [1:0] ph_next;

	assign is_v4  = (s_tdata[3:0] == Ver4);
	assign ver_ok = (ver_q == Ver4) || (ver_q == Ver6);
	assign is_tcp = (key_q.proto == ProtoTcp);
	assign is_udp = (key_q.proto == ProtoUdp);

	assign key_match = (rd_row.src_hi == key_q.src_hi) && (rd_row.src_lo == key_q.src_lo)
		&& (rd_row.dst_hi == key_q.dst_hi) && (rd_row.dst_lo == key_q.dst_lo)
		&& (rd_row.ports == key_q.ports) && (rd_row.proto == key_q.proto);

	assign age = 32'(key_q.stamp - hit_row_q.stamp);
	// links beyond the mask width never count
	assign hit_link_live = !hit_row_q.link[2] && mask_q[hit_row_q.link[1:0]];

	always_comb begin
		ph_next = hit_row_q.phase;
		if (ph_next == PhConnecting && flags_q[1])
			ph_next = PhConnected;
		else if (ph_next == PhClosing && flags_q[1])
			ph_next = PhClosed;
		if (ph_next != PhClosed && flags_q[2])
			ph_next = PhClosing;
	end

	fswls_table u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_addr  (scan_q[FlowW-1:0]),
		.rd_row   (rd_row),
		.rd_valid (rd_valid),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_row   (wr_row),
		.vld_set  (vld_set),
		.vld_clr  (vld_clr),
		.vld_addr (vld_addr)
	);

	assign preq.start = (state_q == ST_DECIDE) && pick_needed;
	assign preq.draw  = draw_q;
	assign preq.mask  = mask_q;

	fswls_pick u_pick (
		.clk    (clk),
		.arst_n (arst_n),
		.weight (weight_q),
		.req    (preq),
		.rsp    (prsp)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (s_tvalid && s_tready) state_d = ST_SCAN;
			ST_SCAN: begin
				if (!ver_ok)
					state_d = ST_APPLY;
				else if (!(is_tcp || is_udp))
					state_d = ST_WAIT;
				else if (int'(scan_q) == Flows - 1)
					state_d = ST_WAIT;
			end
			ST_WAIT:   if (!chk_v_q) state_d = ST_DECIDE;
			ST_DECIDE: state_d = pick_needed ? ST_PICK : ST_APPLY;
			ST_PICK:   if (prsp.done) state_d = ST_APPLY;
			ST_APPLY:  state_d = ST_OUT;
			ST_OUT:    if (!m_tvalid || m_tready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// need-a-pick decision from the scan outcome
	always_comb begin
		pick_needed = 1'b1;
		if (hit_q && is_udp)
			pick_needed = (age > {24'd0, stale_q}) || !hit_link_live;
		else if (hit_q && is_tcp)
			pick_needed = !hit_link_live;
	end

	// table write decisions
	always_comb begin
		wr_en    = 1'b0;
		vld_set  = 1'b0;
		vld_clr  = 1'b0;
		wr_addr  = hit_idx_q;
		vld_addr = hit_idx_q;
		wr_row   = key_q;
		out_ns_q_d = 1'b0;
		if (state_q == ST_APPLY && ver_ok && (is_tcp || is_udp)) begin
			if (hit_q && is_udp && age > {24'd0, stale_q}) begin
				wr_row.link  = {1'b0, pick_link_q};
				wr_row.phase = PhConnected;
				wr_en   = pick_ok_q;
				vld_clr = !pick_ok_q;
			end else if (hit_q && is_udp) begin
				wr_row       = hit_row_q;
				wr_row.stamp = key_q.stamp;
				if (need_pick_q && pick_ok_q)
					wr_row.link = {1'b0, pick_link_q};
				wr_en = 1'b1;
			end else if (hit_q) begin
				wr_row       = hit_row_q;
				wr_row.stamp = key_q.stamp;
				wr_row.phase = ph_next;
				if (need_pick_q && pick_ok_q)
					wr_row.link = {1'b0, pick_link_q};
				wr_en   = (ph_next != PhClosed);
				vld_clr = (ph_next == PhClosed);
			end else if (pick_ok_q && (is_udp || flags_q[0])) begin
				wr_row.link  = {1'b0, pick_link_q};
				wr_row.phase = is_udp ? PhConnected : PhConnecting;
				wr_addr  = free_idx_q;
				vld_addr = free_idx_q;
				wr_en    = free_q;
				vld_set  = free_q;
				out_ns_q_d = !free_q;
			end
		end
	end

	// datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q      <= '0;
			chk_v_q     <= 1'b0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			need_pick_q <= 1'b0;
			pick_ok_q   <= 1'b0;
			m_tvalid    <= 1'b0;
		end else begin
			if (state_q == ST_OUT && (!m_tvalid || m_tready))
				m_tvalid <= 1'b1;
			else if (m_tready)
				m_tvalid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					scan_q  <= '0;
					chk_v_q <= 1'b0;
					hit_q   <= 1'b0;
					free_q  <= 1'b0;
					pick_ok_q <= 1'b0;
					if (s_tvalid && s_tready) begin
						ver_q        <= s_tdata[3:0];
						key_q.src_hi <= is_v4 ? 64'd0 : s_tdata[67:4];
						key_q.src_lo <= is_v4 ? {32'h0000FFFF, s_tdata[99:68]} : s_tdata[131:68];
						key_q.dst_hi <= is_v4 ? 64'd0 : s_tdata[195:132];
						key_q.dst_lo <= is_v4 ? {32'h0000FFFF, s_tdata[227:196]}
							: s_tdata[259:196];
						key_q.ports  <= {s_tdata[275:260], s_tdata[291:276]};
						key_q.proto  <= s_tdata[299:292];
						key_q.link   <= '0;
						key_q.phase  <= '0;
						key_q.stamp  <= s_tdata[334:303];
						flags_q      <= s_tdata[302:300];
						draw_q       <= s_tdata[365:335];
						mask_q       <= s_tdata[369:366];
					end
				end
				ST_SCAN, ST_WAIT: begin
					if (state_q == ST_SCAN && ver_ok && (is_tcp || is_udp)) begin
						scan_q  <= FlowCntW'(scan_q + 1'b1);
						chk_q   <= scan_q;
						chk_v_q <= 1'b1;
					end else begin
						chk_v_q <= 1'b0;
					end
					if (chk_v_q) begin
						if (rd_valid) begin
							if (!hit_q && key_match) begin
								hit_q     <= 1'b1;
								hit_idx_q <= chk_q[FlowW-1:0];
								hit_row_q <= rd_row;
							end
						end else if (!free_q) begin
							free_q     <= 1'b1;
							free_idx_q <= chk_q[FlowW-1:0];
						end
					end
				end
				ST_DECIDE: begin
					need_pick_q <= pick_needed;
					if (!pick_needed) begin
						pick_ok_q   <= 1'b1;
						pick_link_q <= hit_row_q.link[1:0];
					end
				end
				ST_PICK: begin
					if (prsp.done) begin
						pick_ok_q   <= prsp.ok;
						pick_link_q <= prsp.link;
					end
				end
				ST_APPLY: begin
					out_valid_q <= ver_ok && pick_ok_q;
					out_link_q  <= (ver_ok && pick_ok_q) ? pick_link_q : 2'd0;
					out_ns_q    <= out_ns_q_d;
				end
				ST_OUT: begin
					if (!m_tvalid || m_tready)
						m_tdata_q <= {4'd0, out_ns_q, out_link_q, out_valid_q};
				end
				default: ;
			endcase
		end
	end

	// input side is open only while the sequencer idles
	assign s_tready = (state_q == ST_IDLE);
	assign m_tdata  = m_tdata_q;

`ifndef SYNTHESIS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !s_tready) else $error("ready while busy");
	a_pick_in_pick: assert property (@(posedge clk) disable iff (!arst_n)
		prsp.done |-> (state_q == ST_PICK)) else $error("stray pick result");
	a_one_valid_op: assert property (@(posedge clk) disable iff (!arst_n)
		!(vld_set && vld_clr)) else $error("valid set and clear together");
	a_wr_apply: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == ST_APPLY)) else $error("table write outside apply");
`endif

endmodule

@@ tb/tb_flow_sticky_weighted_link_select.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_flow_sticky_weighted_link_select: self-checking bench for the link selector
// Drives packet words with random gaps and random output stalls. A local flow
// table model predicts each result word (hand-typed ones aside), and the bench
// checks it field by field. Stimulus is a directed table first, then a table
// fill and drain with TCP flows, then random phases of sticky flows plus noise
// under several weight and stale-limit settings.
// ----------------------------------------------------------------------------
module tb_flow_sticky_weighted_link_select;
	import fswls_pkg::*;

	// one packet, unpacked
	typedef struct {
		logic [3:0]  ver;
		logic [63:0] shi, slo, dhi, dlo;
		logic [15:0] sp, dp;
		logic [7:0]  proto;
		logic [2:0]  flags;
		logic [31:0] now;
		logic [30:0] draw;
		logic [3:0]  mask;
	} pkt_t;

	typedef struct {
		pkt_t        p;
		bit          typed;   // result written in by hand
		logic [7:0]  res;
	} drow_t;

	localparam int PoolN = 40;
	localparam int FillN = 66;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [375:0] s_tdata = '0;   // fields as listed at the DUT port
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [7:0]   m_tdata;        // link_valid, link_index[2:1], flow_not_stored
	logic         cfg_we = 1'b0;
	logic [2:0]   cfg_index = '0;
	logic [7:0]   cfg_data = '0;

	// local copy of registers and flow table
	logic [7:0]  lw [Links];
	logic [7:0]  stale_lim;
	bit          fl_valid [Flows];
	logic [63:0] fl_shi [Flows], fl_slo [Flows], fl_dhi [Flows], fl_dlo [Flows];
	logic [31:0] fl_ports [Flows];
	logic [7:0]  fl_proto [Flows];
	logic [2:0]  fl_link [Flows];
	logic [1:0]  fl_phase [Flows];
	logic [31:0] fl_stamp [Flows];

	logic [7:0] pending_links [$];
	int  errors = 0;
	int  n_words = 0, n_results = 0, n_nolink = 0, n_unstored = 0;
	bit  hold_long = 1'b0;
	bit  quiet = 1'b0;

	flow_sticky_weighted_link_select i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("Verification failed");
		$finish;
	end

	function automatic logic [7:0] res(bit v, logic [1:0] idx, bit nst);
		return {4'b0, nst, idx, v};
	endfunction

	function automatic logic [375:0] pack(pkt_t p);
		return {6'b0, p.mask, p.draw, p.now, p.flags, p.proto, p.dp, p.sp,
			p.dlo, p.dhi, p.slo, p.shi, p.ver};
	endfunction

	function automatic bit link_live(int l, logic [3:0] mask);
		return (l >= 0) && (l < Links) && (l < 4) && mask[l];
	endfunction

	// weighted pick: draw mod sum of live weights, then cumulative walk
	function automatic int weighted_pick(logic [30:0] draw, logic [3:0] mask);
		logic [31:0] total, r, acc;
		total = 0;
		acc = 0;
		for (int i = 0; i < Links; i++)
			if (link_live(i, mask)) total += lw[i];
		if (total == 0) return -1;
		r = {1'b0, draw} % total;
		for (int i = 0; i < Links; i++) begin
			if (link_live(i, mask)) begin
				acc += lw[i];
				if (acc > r) return i;
			end
		end
		return -1;
	endfunction

	// advance the flow table by one packet and return the result word
	function automatic logic [7:0] predict_link(pkt_t p);
		logic [63:0] shi, slo, dhi, dlo;
		logic [31:0] ports, age;
		logic [1:0]  ph, nph;
		int lk, hit, fr, pk;
		bit nst, store;
		shi = p.shi; slo = p.slo; dhi = p.dhi; dlo = p.dlo;
		ports = {p.sp, p.dp};
		lk = -1; hit = -1; fr = -1; nst = 0; store = 0; nph = PhConnected;
		if (p.ver == Ver4) begin
			shi = '0; slo = {32'h0000FFFF, p.slo[31:0]};
			dhi = '0; dlo = {32'h0000FFFF, p.dlo[31:0]};
		end
		if (p.ver == Ver4 || p.ver == Ver6) begin
			if (p.proto == ProtoTcp || p.proto == ProtoUdp) begin
				for (int i = 0; i < Flows; i++) begin
					if (fl_valid[i]) begin
						if (hit < 0 && fl_shi[i] == shi && fl_slo[i] == slo &&
								fl_dhi[i] == dhi && fl_dlo[i] == dlo &&
								fl_ports[i] == ports && fl_proto[i] == p.proto)
							hit = i;
					end else if (fr < 0) begin
						fr = i;
					end
				end
			end
			if (p.proto == ProtoUdp) begin
				if (hit >= 0) begin
					age = p.now - fl_stamp[hit];
					if (age > stale_lim) begin
						// idle too long: free the row and pick again into it
						fl_valid[hit] = 0;
						fr = hit;
						lk = weighted_pick(p.draw, p.mask);
						store = lk >= 0;
					end else begin
						lk = fl_link[hit];
						if (!link_live(lk, p.mask)) begin
							pk = weighted_pick(p.draw, p.mask);
							if (pk >= 0) fl_link[hit] = pk[2:0];
							lk = pk;
						end
						fl_stamp[hit] = p.now;
					end
				end else begin
					lk = weighted_pick(p.draw, p.mask);
					store = lk >= 0;
				end
			end else if (p.proto == ProtoTcp) begin
				if (hit >= 0) begin
					ph = fl_phase[hit];
					lk = fl_link[hit];
					if (!link_live(lk, p.mask)) begin
						pk = weighted_pick(p.draw, p.mask);
						if (pk >= 0) fl_link[hit] = pk[2:0];
						lk = pk;
					end
					if (ph == PhConnecting && p.flags[1]) ph = PhConnected;
					else if (ph == PhClosing && p.flags[1]) ph = PhClosed;
					if (ph != PhClosed && p.flags[2]) ph = PhClosing;
					if (ph == PhClosed) begin
						fl_valid[hit] = 0;
					end else begin
						fl_phase[hit] = ph;
						fl_stamp[hit] = p.now;
					end
				end else begin
					lk = weighted_pick(p.draw, p.mask);
					if (p.flags[0]) begin
						store = lk >= 0;
						nph = PhConnecting;
					end
				end
			end else begin
				lk = weighted_pick(p.draw, p.mask);
			end
			if (store) begin
				if (fr >= 0) begin
					fl_valid[fr] = 1;
					fl_shi[fr] = shi; fl_slo[fr] = slo;
					fl_dhi[fr] = dhi; fl_dlo[fr] = dlo;
					fl_ports[fr] = ports;
					fl_proto[fr] = p.proto;
					fl_link[fr] = lk[2:0];
					fl_phase[fr] = nph;
					fl_stamp[fr] = p.now;
				end else begin
					nst = 1;
				end
			end
		end
		return res(lk >= 0, (lk >= 0) ? lk[1:0] : 2'b0, nst);
	endfunction

	function automatic int draw_gap();
		if (quiet || $urandom_range(0, 3) == 0) return 0;
		return $urandom_range(0, 18);
	endfunction

	// offer one word; predict once the DUT takes it (called at a falling edge)
	task automatic send_word(pkt_t p, bit typed, logic [7:0] hand_res);
		int n;
		logic [7:0] got;
		n = draw_gap();
		if (n > 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(negedge clk);
		end
		s_tdata <= pack(p);
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		got = predict_link(p);
		pending_links.push_back(typed ? hand_res : got);
		n_words++;
		@(negedge clk);
	endtask

	// wait out every pending result plus the block's own latency
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_links.size() != 0) @(negedge clk);
		repeat (150) @(negedge clk);
	endtask

	task automatic put_reg(logic [2:0] idx, logic [7:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == RegStale) stale_lim = v;
		else lw[idx] = v;
	endtask

	task automatic set_regs(logic [7:0] w0, w1, w2, w3, st);
		put_reg(RegLink0, w0);
		put_reg(RegLink1, w1);
		put_reg(RegLink2, w2);
		put_reg(RegLink3, w3);
		put_reg(RegStale, st);
	endtask

	function automatic pkt_t mk(logic [3:0] ver, logic [63:0] shi, slo, dhi, dlo,
			logic [15:0] sp, dp, logic [7:0] proto, logic [2:0] flags,
			logic [31:0] now, logic [30:0] draw, logic [3:0] mask);
		pkt_t p;
		p.ver = ver; p.shi = shi; p.slo = slo; p.dhi = dhi; p.dlo = dlo;
		p.sp = sp; p.dp = dp; p.proto = proto; p.flags = flags;
		p.now = now; p.draw = draw; p.mask = mask;
		return p;
	endfunction

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	// random flow pool with sticky keys
	pkt_t pool [PoolN];
	logic [31:0] clock_s = 32'd1000;

	task automatic random_phase(int count);
		pkt_t p;
		int k;
		for (int n = 0; n < count; n++) begin
			clock_s += $urandom_range(0, 2);
			if ($urandom_range(0, 99) < 85) begin
				k = $urandom_range(0, PoolN - 1);
				p = pool[k];
				case ($urandom_range(0, 19))
					0, 1, 2, 3, 4, 5: p.flags = 3'b001;   // SYN
					6, 7, 8, 9, 10, 11, 12, 13: p.flags = 3'b010;  // ACK
					14, 15, 16: p.flags = 3'b100;         // FIN
					default: p.flags = 3'($urandom_range(0, 7));
				endcase
			end else begin
				// noise: any version, mostly other protocols, fresh keys
				p = mk(4'($urandom_range(0, 15)), rnd64(), rnd64(), rnd64(), rnd64(),
					16'($urandom), 16'($urandom), 8'($urandom_range(0, 255)),
					3'($urandom_range(0, 7)), 0, 0, 0);
			end
			p.now = ($urandom_range(0, 31) == 0) ? $urandom : clock_s;
			p.draw = 31'($urandom);
			p.mask = ($urandom_range(0, 9) < 7) ? 4'hF : 4'($urandom_range(0, 15));
			send_word(p, 1'b0, '0);
		end
	endtask

	// output side: random stalls, one long hold-off on request
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_long) begin
				hold_long = 1'b0;
				n = 400;
			end else begin
				n = draw_gap();
			end
			if (n > 0) begin
				m_tready <= 1'b0;
				repeat (n) @(negedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	// result check against the oldest pending word
	always @(posedge clk) begin
		logic [7:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			n_results++;
			if (!m_tdata[0]) n_nolink++;
			if (m_tdata[3]) n_unstored++;
			if (pending_links.size() == 0) begin
				errors++;
				$display("%0t: result word %h with none pending", $time, m_tdata);
			end else begin
				want = pending_links.pop_front();
				if (m_tdata[0] !== want[0]) begin
					errors++;
					$display("%0t: link_valid expected %b got %b", $time, want[0], m_tdata[0]);
				end
				if (m_tdata[2:1] !== want[2:1]) begin
					errors++;
					$display("%0t: link_index expected %0d got %0d", $time,
						want[2:1], m_tdata[2:1]);
				end
				if (m_tdata[3] !== want[3]) begin
					errors++;
					$display("%0t: flow_not_stored expected %b got %b", $time,
						want[3], m_tdata[3]);
				end
			end
		end
	end

	initial begin
		drow_t dir [22];
		pkt_t fill [FillN];
		pkt_t p;
		logic [63:0] ones;
		ones = '1;
		for (int i = 0; i < Links; i++) lw[i] = 8'd1;
		stale_lim = 8'd5;
		for (int i = 0; i < Flows; i++) fl_valid[i] = 0;

		// directed rows: weights 1 each, stale limit 5
		// bad versions, no live link, single live link
		dir[0] = '{mk(4'd0, 0, 0, 0, 0, 0, 0, ProtoUdp, 0, 0, 0, 4'hF), 1, res(0, 0, 0)};
		dir[1] = '{mk(4'd15, ones, ones, ones, ones, 16'hFFFF, 16'hFFFF, 8'hFF, 3'h7,
			'1, '1, 4'hF), 1, res(0, 0, 0)};
		dir[2] = '{mk(Ver4, 0, 0, 0, 0, 0, 0, 8'd1, 0, 0, 5, 4'h0), 1, res(0, 0, 0)};
		dir[3] = '{mk(Ver4, 0, 0, 0, 0, 0, 0, 8'd1, 0, 0, '1, 4'h1), 1, res(1, 0, 0)};
		dir[4] = '{mk(Ver6, 0, 0, 0, 0, 0, 0, 8'hFF, 0, 0, 0, 4'h8), 1, res(1, 3, 0)};
		// UDP flow: new, fresh hit, stale, clock backwards, dead link, no link
		p = mk(Ver6, ones, 0, 0, ones, 16'hFFFF, 16'h0, ProtoUdp, 0, 100, 2, 4'hF);
		dir[5] = '{p, 1, res(1, 2, 0)};
		p.now = 105; p.draw = 1;
		dir[6] = '{p, 1, res(1, 2, 0)};
		p.now = 111;
		dir[7] = '{p, 1, res(1, 1, 0)};
		p.now = 50; p.draw = 3;
		dir[8] = '{p, 1, res(1, 3, 0)};
		p.mask = 4'b0111; p.draw = 0;
		dir[9] = '{p, 0, '0};
		p.mask = 4'h0;
		dir[10] = '{p, 1, res(0, 0, 0)};
		// TCP flow through its phases; IPv4 with junk in the upper bits
		p = mk(Ver4, ones, 64'hDEADBEEF_C0A80001, 64'h1234, 64'h55AA55AA_0A000002,
			16'd1024, 16'd80, ProtoTcp, 3'b000, 200, 1, 4'hF);
		dir[11] = '{p, 0, '0};
		p.flags = 3'b001;
		dir[12] = '{p, 1, res(1, 1, 0)};
		p.flags = 3'b010; p.draw = 3;
		dir[13] = '{p, 1, res(1, 1, 0)};
		p.flags = 3'b100;
		dir[14] = '{p, 1, res(1, 1, 0)};
		p.flags = 3'b010; p.mask = 4'b1101;
		dir[15] = '{p, 0, '0};
		p.flags = 3'b000; p.mask = 4'hF;
		dir[16] = '{p, 0, '0};
		p.flags = 3'b111;
		dir[17] = '{p, 0, '0};
		dir[18] = '{p, 0, '0};
		p.flags = 3'b010;
		dir[19] = '{p, 0, '0};
		// IPv4 flow then the same flow written as a mapped IPv6 address
		p = mk(Ver4, 0, 64'hC0A80101, 0, 64'hC0A80102, 16'd53, 16'd53, ProtoUdp, 0,
			300, 31'($urandom), 4'hF);
		dir[20] = '{p, 0, '0};
		p.ver = Ver6; p.slo = 64'h0000FFFF_C0A80101; p.dlo = 64'h0000FFFF_C0A80102;
		p.now = 301;
		dir[21] = '{p, 0, '0};

		for (int i = 0; i < PoolN; i++) begin
			pool[i] = mk(($urandom_range(0, 1) != 0) ? Ver4 : Ver6, rnd64(), rnd64(),
				rnd64(), rnd64(), 16'($urandom), 16'($urandom),
				($urandom_range(0, 1) != 0) ? ProtoTcp : ProtoUdp, 0, 0, 0, 0);
		end
		for (int i = 0; i < FillN; i++) begin
			fill[i] = mk(Ver6, 64'(i), rnd64(), rnd64(), rnd64(), 16'($urandom),
				16'($urandom), ProtoTcp, 3'b001, 500, 0, 4'hF);
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < 22; i++) send_word(dir[i].p, dir[i].typed, dir[i].res);
		settle();

		// fill the table past full with TCP opens, then close every flow
		set_regs(8'd1, 8'd2, 8'd3, 8'd4, 8'd255);
		for (int i = 0; i < FillN; i++) begin
			fill[i].draw = 31'($urandom);
			send_word(fill[i], 1'b0, '0);
		end
		for (int i = 0; i < FillN; i++) begin
			fill[i].flags = 3'b100;
			send_word(fill[i], 1'b0, '0);
			fill[i].flags = 3'b010;
			send_word(fill[i], 1'b0, '0);
		end
		settle();

		set_regs(8'd3, 8'd1, 8'd0, 8'd7, 8'd2);
		random_phase(300);
		settle();
		quiet = 1'b1;
		set_regs(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
		random_phase(300);
		settle();
		quiet = 1'b0;
		set_regs(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
		random_phase(60);
		settle();
		set_regs(8'd0, 8'd255, 8'd0, 8'd1, 8'd0);
		random_phase(250);
		settle();
		set_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom_range(0, 8)));
		random_phase(300);
		settle();
		// long output hold-off while words keep coming
		set_regs(8'd1, 8'd1, 8'd1, 8'd1, 8'd5);
		hold_long = 1'b1;
		random_phase(300);
		settle();

		$display("Covered %0d packet words, %0d results (%0d without a link, %0d unstored)",
			n_words, n_results, n_nolink, n_unstored);
		$display("over directed cases, a full-table fill and six register settings");
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/fswls_pkg.sv
rtl/fswls_pick.sv
rtl/fswls_table.sv
rtl/flow_sticky_weighted_link_select.sv
tb/tb_flow_sticky_weighted_link_select.sv
